// File: design/ssm_pkg.sv
package ssm_pkg;

  localparam int CHANNELS_DEF    = 64;
  localparam int STATES_DEF      = 16;
  localparam int EXP_ENTRIES_DEF = 256;

  localparam int S_DATA_W = 96;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 40;

  typedef enum logic [1:0] {
    FUNC_DECAY = 2'd0,
    FUNC_SKIP  = 2'd1,
    FUNC_SCAN  = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROD,
    ST_EXP,
    ST_MUL,
    ST_HNEW,
    ST_CH,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic rd;
    logic dec_we;
    logic skip_we;
    logic hid_we;
  } store_ctl_t;

  function automatic int wrap_mod(input int v, input int m);
    int r;
    r = v;
    while (r >= m) begin
      r = r - m;
    end
    return r;
  endfunction

  function automatic longint div_trunc(input longint num, input longint den);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    logic            neg;
    neg = (num < 0) ^ (den < 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    q   = '0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint exp_q30(input longint num, input longint den);
    longint one;
    longint t;
    longint term;
    longint sum;
    one  = longint'(1) <<< 30;
    t    = div_trunc(num * one, den);
    term = one;
    sum  = one;
    for (int k = 1; k <= 24; k++) begin
      term = div_trunc(term * t, longint'(k) * one);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic longint unsigned mul_q30(input longint unsigned acc,
                                              input longint unsigned r);
    return (((acc >> 32) * r) << 2) + (((acc & 64'hFFFF_FFFF) * r) >> 30);
  endfunction

  function automatic logic [31:0] exp_entry(input int entries, input int i);
    longint unsigned acc;
    longint unsigned half;
    longint unsigned stp;
    longint unsigned rnd;
    acc  = 64'd1 << 40;
    half = longint'(exp_q30(-1, 2));
    stp  = longint'(exp_q30(16, longint'(entries)));
    for (int j = 0; j < 16; j++) begin
      acc = mul_q30(acc, half);
    end
    for (int j = 0; j < i; j++) begin
      acc = mul_q30(acc, stp);
    end
    rnd = (acc + (64'd1 << 23)) >> 24;
    return rnd[31:0];
  endfunction

endpackage

// File: design/ssm_store.sv
module ssm_store import ssm_pkg::*; #(
  parameter int CELLS    = CHANNELS_DEF * STATES_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int CW       = (CELLS > 1) ? $clog2(CELLS) : 1,
  parameter int CHA      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic               clk,
  input  store_ctl_t         ctl,
  input  logic [CW-1:0]      rd_cell,
  input  logic [CW-1:0]      wr_cell,
  input  logic [CW-1:0]      hid_cell,
  input  logic [CHA-1:0]     skip_addr,
  input  logic signed [15:0] coef,
  input  logic signed [31:0] hid_wdata,
  output logic signed [15:0] dec_q,
  output logic signed [31:0] hid_q,
  output logic signed [15:0] skip_q
);

  logic signed [15:0] dec_mem  [CELLS];
  logic signed [31:0] hid_mem  [CELLS];
  logic signed [15:0] skip_mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (ctl.dec_we) begin
      dec_mem[wr_cell] <= coef;
    end
    if (ctl.rd) begin
      dec_q <= dec_mem[rd_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hid_we) begin
      hid_mem[hid_cell] <= hid_wdata;
    end
    if (ctl.rd) begin
      hid_q <= hid_mem[rd_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.skip_we) begin
      skip_mem[skip_addr] <= coef;
    end
    if (ctl.rd) begin
      skip_q <= skip_mem[skip_addr];
    end
  end

endmodule

// File: design/ssm_exp_lut.sv
module ssm_exp_lut import ssm_pkg::*; #(
  parameter int EXP_ENTRIES = EXP_ENTRIES_DEF,
  parameter int IW          = $clog2(EXP_ENTRIES)
) (
  input  logic          clk,
  input  logic [IW-1:0] idx,
  output logic [31:0]   e_q
);

  logic [31:0] lut [EXP_ENTRIES];

  for (genvar g = 0; g < EXP_ENTRIES; g++) begin : g_lut
    localparam logic [31:0] ENTRY = exp_entry(EXP_ENTRIES, g);
    assign lut[g] = ENTRY;
  end

  always_ff @(posedge clk) begin
    e_q <= lut[idx];
  end

endmodule

// File: design/selective_ssm_scan_top.sv
// channel | dir | tdata (low bit up)                              | tuser            | tlast
// s_      | in  | channel, state_idx, coef, x, dt, b, c (96 bits) | func, seq_start  | last_state
// m_      | out | out_channel, y_value (40 bits)                  | saturated        | -
// Load words are accepted back to back while idle; a scan word runs through the multiply,
// exponential table and accumulate sequence, and an output step when it emits a result.
// The memories have a registered read; the hidden store write follows its read.
// After reset a clearing pass zeroes every hidden store cell.
// A result waits in the output register; only the next result stalls on m_tready.
module selective_ssm_scan_top import ssm_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int STATES      = STATES_DEF,
  parameter int EXP_ENTRIES = EXP_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // channel, state_idx, coef, x, dt, b, c
  input  logic [S_USER_W-1:0] s_tuser,  // func, seq_start
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // out_channel, y_value
  output logic [0:0]          m_tuser   // saturated
);

  localparam int CELLS = CHANNELS * STATES;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CHA   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = $clog2(EXP_ENTRIES);
  localparam int EW    = $clog2(EXP_ENTRIES + 1);
  localparam int PW    = 20 + EW;

  state_t     state, state_next;
  store_ctl_t ctl;

  logic [5:0] ch_tab [64];
  logic [3:0] st_tab [16];
  for (genvar g = 0; g < 64; g++) begin : g_ch
    localparam logic [5:0] CHM = 6'(wrap_mod(g, CHANNELS));
    assign ch_tab[g] = CHM;
  end
  for (genvar g = 0; g < 16; g++) begin : g_st
    localparam logic [3:0] STM = 4'(wrap_mod(g, STATES));
    assign st_tab[g] = STM;
  end

  logic [1:0]  func_in;
  logic [5:0]  ch_mod;
  logic [3:0]  st_mod;
  logic [31:0] cell_full;
  logic [CW-1:0] cell_in;
  logic        accept;

  assign func_in   = s_tuser[1:0];
  assign ch_mod    = ch_tab[s_tdata[5:0]];
  assign st_mod    = st_tab[s_tdata[9:6]];
  assign cell_full = 32'(ch_mod) * 32'(STATES) + 32'(st_mod);
  assign cell_in   = cell_full[CW-1:0];
  assign accept    = s_tvalid && s_tready;

  logic [CW-1:0]      cell_r;
  logic [CW-1:0]      clr_cnt;
  logic [5:0]         ch_r;
  logic signed [15:0] x_r, dt_r, b_r, c_r;
  logic               seq_r, last_r;

  logic signed [15:0] dec_q, skip_q;
  logic signed [31:0] hid_q;
  logic signed [31:0] hnew;

  ssm_store #(
    .CELLS(CELLS), .CHANNELS(CHANNELS), .CW(CW), .CHA(CHA)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .rd_cell   (cell_in),
    .wr_cell   (cell_in),
    .hid_cell  ((state == ST_CLEAR) ? clr_cnt : cell_r),
    .skip_addr (CHA'(ch_mod)),
    .coef      ($signed(s_tdata[25:10])),
    .hid_wdata ((state == ST_CLEAR) ? 32'sd0 : hnew),
    .dec_q     (dec_q),
    .hid_q     (hid_q),
    .skip_q    (skip_q)
  );

  logic signed [31:0] p_r, dtb_r, hprev_r, xs_r;
  logic signed [15:0] skip_r;
  logic signed [47:0] dbx_r, chp_r;
  logic signed [64:0] eh_r;
  logic signed [47:0] acc;
  logic               sat_flag, clip_r;
  logic [31:0]        e_q;
  logic [19:0]        p_off;
  logic [PW-1:0]      idx_prod;
  logic [EW-1:0]      idx_full;
  logic [IW-1:0]      idx;

  always_comb begin
    if (p_r < -32'sd524288) begin
      p_off = '0;
    end else if (p_r > 32'sd524287) begin
      p_off = '1;
    end else begin
      p_off = p_r[19:0] ^ 20'h80000;
    end
    idx_prod = PW'(p_off) * PW'(EXP_ENTRIES);
    idx_full = idx_prod[PW-1:20];
    if (idx_full >= EW'(EXP_ENTRIES)) begin
      idx = IW'(EXP_ENTRIES - 1);
    end else begin
      idx = idx_full[IW-1:0];
    end
  end

  ssm_exp_lut #(.EXP_ENTRIES(EXP_ENTRIES), .IW(IW)) u_lut (
    .clk (clk),
    .idx (idx),
    .e_q (e_q)
  );

  logic signed [64:0] eh_t;
  logic signed [47:0] db_t, ch_t;
  logic signed [49:0] hsum, ysum;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_new;
  logic               hclip, aclip, yclip;
  logic signed [31:0] ysat;
  logic               out_fire;

  always_comb begin
    eh_t  = eh_r + 65'sd32768;
    db_t  = dbx_r + 48'sd128;
    hsum  = $signed(eh_t[64:16]) + $signed(db_t[47:8]);
    hclip = (hsum > 50'sd2147483647) || (hsum < -50'sd2147483648);
    if (hsum > 50'sd2147483647) begin
      hnew = 32'sh7FFFFFFF;
    end else if (hsum < -50'sd2147483648) begin
      hnew = 32'sh80000000;
    end else begin
      hnew = hsum[31:0];
    end
    ch_t    = chp_r + 48'sd128;
    acc_sum = acc + $signed(ch_t[47:8]);
    aclip   = (acc_sum > 49'sh0_7FFF_FFFF_FFFF) || (acc_sum < -49'sh0_8000_0000_0000);
    if (acc_sum > 49'sh0_7FFF_FFFF_FFFF) begin
      acc_new = 48'sh7FFF_FFFF_FFFF;
    end else if (acc_sum < -49'sh0_8000_0000_0000) begin
      acc_new = 48'sh8000_0000_0000;
    end else begin
      acc_new = acc_sum[47:0];
    end
    ysum  = acc + xs_r;
    yclip = (ysum > 50'sd2147483647) || (ysum < -50'sd2147483648);
    if (ysum > 50'sd2147483647) begin
      ysat = 32'sh7FFFFFFF;
    end else if (ysum < -50'sd2147483648) begin
      ysat = 32'sh80000000;
    end else begin
      ysat = ysum[31:0];
    end
  end

  assign out_fire = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == CW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept && func_in == FUNC_SCAN) state_next = ST_PROD;
      ST_PROD:  state_next = ST_EXP;
      ST_EXP:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_HNEW;
      ST_HNEW:  state_next = ST_CH;
      ST_CH:    state_next = ST_ACC;
      ST_ACC:   state_next = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:   if (out_fire) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready    = (state == ST_IDLE);
    ctl.rd      = accept && func_in == FUNC_SCAN;
    ctl.dec_we  = accept && func_in == FUNC_DECAY;
    ctl.skip_we = accept && func_in == FUNC_SKIP;
    ctl.hid_we  = (state == ST_CLEAR) || (state == ST_HNEW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      acc      <= '0;
      sat_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_ACC) begin
        acc <= acc_new;
        if (!last_r) begin
          sat_flag <= sat_flag | clip_r | aclip;
        end
      end
      if (out_fire) begin
        acc      <= '0;
        sat_flag <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      cell_r <= cell_in;
      ch_r   <= ch_mod;
      x_r    <= $signed(s_tdata[41:26]);
      dt_r   <= $signed(s_tdata[57:42]);
      b_r    <= $signed(s_tdata[73:58]);
      c_r    <= $signed(s_tdata[89:74]);
      seq_r  <= s_tuser[2];
      last_r <= s_tlast;
    end
    unique case (state)
      ST_PROD: begin
        p_r     <= dt_r * dec_q;
        dtb_r   <= dt_r * b_r;
        hprev_r <= seq_r ? 32'sd0 : hid_q;
        skip_r  <= skip_q;
      end
      ST_EXP:  dbx_r <= dtb_r * x_r;
      ST_MUL:  eh_r <= $signed({1'b0, e_q}) * hprev_r;
      ST_HNEW: begin
        chp_r  <= c_r * hnew;
        clip_r <= hclip;
      end
      ST_CH:   xs_r <= x_r * skip_r;
      ST_ACC:  clip_r <= clip_r | aclip;
      ST_OUT: begin
        if (out_fire) begin
          m_tdata <= {2'b00, ysat, ch_r};
          m_tuser <= sat_flag | clip_r | yclip;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_hid_write: assert property (@(posedge clk) disable iff (rst)
    ctl.hid_we |-> (state == ST_HNEW || state == ST_CLEAR))
    else $error("hidden store written outside update");
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[1:0] == FUNC_SCAN) |=> state == ST_PROD)
    else $error("scan word did not start sequence");
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> (acc == '0 && !sat_flag))
    else $error("accumulator not cleared after result");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result without output step");
`endif

endmodule

// File: tb/sv/selective_ssm_scan_top_tb.sv
module selective_ssm_scan_top_tb import ssm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = CHANNELS_DEF;
  localparam int NST = STATES_DEF;
  localparam int NEXP = EXP_ENTRIES_DEF;
  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  channel;
    logic [3:0]  state_idx;
    logic [15:0] coef;
    logic [15:0] x;
    logic [15:0] dt;
    logic [15:0] b;
    logic [15:0] c;
    logic        seq;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [5:0]  channel;
    logic [31:0] y;
    logic        sat;
  } result_t;

  typedef struct {
    word_t   w;
    logic    fixed;
    result_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  selective_ssm_scan_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] exp_rom [NEXP];
  int   hid   [NCH*NST];
  shortint decay [NCH*NST];
  shortint gain [NCH];
  longint acc;
  bit   sat_pend;
  result_t pending_y [$];
  int   errors = 0;
  bit   done = 1'b0;

  function automatic longint rshift_round(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v, ref bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void build_exp_rom();
    longint one, t, term, sum;
    longint unsigned a, half, stp;
    for (int pass = 0; pass < 2; pass++) begin
      one = longint'(1) <<< 30;
      t = (pass == 0) ? (-one / 2) : (16 * one / NEXP);
      term = one;
      sum = one;
      for (int k = 1; k <= 24; k++) begin
        term = term * t / (longint'(k) * one);
        sum += term;
      end
      if (pass == 0) half = sum;
      else stp = sum;
    end
    a = 64'd1 << 40;
    for (int i = 0; i < 16; i++)
      a = (((a >> 32) * half) << 2) + (((a & 64'hFFFF_FFFF) * half) >> 30);
    for (int i = 0; i < NEXP; i++) begin
      exp_rom[i] = 32'((a + (64'd1 << 23)) >> 24);
      a = (((a >> 32) * stp) << 2) + (((a & 64'hFFFF_FFFF) * stp) >> 30);
    end
  endfunction

  function automatic bit scan_step(word_t w, output result_t r);
    int slot;
    longint p, idx, hp, hn, y;
    bit clip;
    clip = 1'b0;
    slot = w.channel * NST + w.state_idx;
    if (w.func == FUNC_DECAY) begin
      decay[slot] = w.coef;
      return 1'b0;
    end
    if (w.func == FUNC_SKIP) begin
      gain[w.channel] = w.coef;
      return 1'b0;
    end
    if (w.func != FUNC_SCAN) return 1'b0;
    p = longint'($signed(w.dt)) * decay[slot];
    if (p < -524288) p = -524288;
    if (p > 524287) p = 524287;
    idx = ((p + 524288) * NEXP) >>> 20;
    if (idx >= NEXP) idx = NEXP - 1;
    hp = w.seq ? 0 : hid[slot];
    hn = rshift_round(longint'(exp_rom[idx]) * hp, 16)
       + rshift_round(longint'($signed(w.dt)) * $signed(w.b) * $signed(w.x), 8);
    hn = clip32(hn, clip);
    hid[slot] = int'(hn);
    acc += rshift_round(longint'($signed(w.c)) * hn, 8);
    if (acc > ACC_HI) begin
      acc = ACC_HI;
      clip = 1'b1;
    end
    if (acc < ACC_LO) begin
      acc = ACC_LO;
      clip = 1'b1;
    end
    if (!w.last) begin
      if (clip) sat_pend = 1'b1;
      return 1'b0;
    end
    y = clip32(acc + longint'($signed(w.x)) * gain[w.channel], clip);
    r.channel = w.channel;
    r.y = 32'(y);
    r.sat = sat_pend | clip;
    acc = 0;
    sat_pend = 1'b0;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send(word_t w, bit fixed, result_t fr);
    result_t r;
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {w.c, w.b, w.dt, w.x, w.coef, w.state_idx, w.channel};
    s_tuser <= {w.seq, w.func};
    s_tlast <= w.last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (scan_step(w, r)) pending_y.push_back(fixed ? fr : r);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t rand_scan(int ch, int st, bit seq, bit last);
    word_t w;
    w.func = FUNC_SCAN;
    w.channel = 6'(ch);
    w.state_idx = 4'(st);
    w.coef = 16'($urandom);
    w.x = rand16();
    w.dt = rand16();
    w.b = rand16();
    w.c = rand16();
    w.seq = seq;
    w.last = last;
    return w;
  endfunction

  function automatic word_t mk(logic [1:0] f, int ch, int st, logic [15:0] v);
    word_t w;
    w = '0;
    w.func = f;
    w.channel = 6'(ch);
    w.state_idx = 4'(st);
    w.coef = v;
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      result_t got, want;
      got.channel = m_tdata[5:0];
      got.y = m_tdata[37:6];
      got.sat = m_tuser[0];
      if (pending_y.size() == 0) begin
        $display("%0t: unexpected result ch=%0d y=%h sat=%b", $time,
                 got.channel, got.y, got.sat);
        errors++;
      end else begin
        want = pending_y.pop_front();
        if (got.channel !== want.channel)
          $display("%0t: channel expected %0d actual %0d", $time, want.channel, got.channel);
        if (got.y !== want.y)
          $display("%0t: y expected %h actual %h", $time, want.y, got.y);
        if (got.sat !== want.sat)
          $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    int hold;
    @(negedge clk);
    forever begin
      hold = gap_len();
      m_tready <= (hold == 0);
      repeat (hold > 0 ? hold : $urandom_range(1, 8)) @(negedge clk);
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    result_t r;
    word_t w;
    int ch, n, cnt;
    build_exp_rom();
    acc = 0;
    sat_pend = 1'b0;
    foreach (hid[i]) hid[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rw.fixed = 1'b0;
    rw.r = '0;
    rw.w = mk(FUNC_DECAY, 0, 0, 16'h8000);   rows.push_back(rw);
    rw.w = mk(FUNC_DECAY, 63, 15, 16'h7FFF); rows.push_back(rw);
    rw.w = mk(FUNC_SKIP, 0, 0, 16'h0100);    rows.push_back(rw);
    rw.w = mk(FUNC_SKIP, 63, 0, 16'h7FFF);   rows.push_back(rw);
    rw.w = mk(FUNC_NONE, 5, 5, 16'h1234);    rows.push_back(rw);
    // zero inputs after reset: y = x*skip = 0
    rw.w = mk(FUNC_SCAN, 0, 0, 16'h0);
    rw.w.last = 1'b1;
    rw.fixed = 1'b1;
    rw.r = '{channel: 6'd0, y: 32'd0, sat: 1'b0};
    rows.push_back(rw);
    rw.fixed = 1'b0;
    // x=1.0, skip=1.0 -> y = 1.0 exactly with b=0
    rw.w = mk(FUNC_SCAN, 0, 0, 16'h0);
    rw.w.x = 16'h0100;
    rw.w.seq = 1'b1;
    rw.w.last = 1'b1;
    rw.fixed = 1'b1;
    rw.r = '{channel: 6'd0, y: 32'h0001_0000, sat: 1'b0};
    rows.push_back(rw);
    rw.fixed = 1'b0;
    // extremes: saturate h and the output y
    rw.w = rand_scan(63, 15, 1'b1, 1'b0);
    rw.w.x = 16'h8000; rw.w.dt = 16'h8000; rw.w.b = 16'h8000; rw.w.c = 16'h7FFF;
    rows.push_back(rw);
    rw.w = rand_scan(63, 15, 1'b0, 1'b0);
    rw.w.x = 16'h7FFF; rw.w.dt = 16'h7FFF; rw.w.b = 16'h7FFF; rw.w.c = 16'h8000;
    rows.push_back(rw);
    rw.w.func = FUNC_DECAY; rw.w.coef = 16'h0001; rows.push_back(rw);
    rw.w = rand_scan(63, 15, 1'b0, 1'b1);
    rw.w.x = 16'h7FFF; rw.w.dt = 16'h8000; rows.push_back(rw);
    // mixed channels share the accumulator
    rw.w = rand_scan(0, 0, 1'b0, 1'b0);  rows.push_back(rw);
    rw.w = rand_scan(63, 15, 1'b0, 1'b1); rows.push_back(rw);
    rw.w = rand_scan(0, 0, 1'b0, 1'b1);
    rw.w.dt = 16'h8000; rows.push_back(rw);

    foreach (rows[i]) send(rows[i].w, rows[i].fixed, rows[i].r);

    // fill every table entry so random scans never read an unwritten entry
    for (int c = 0; c < NCH; c++) begin
      w = mk(FUNC_SKIP, c, 0, rand16());
      send(w, 1'b0, r);
      for (int s = 0; s < NST; s++) begin
        w = mk(FUNC_DECAY, c, s, 16'($signed($urandom_range(0, 2047)) - 1536));
        if ($urandom_range(0, 9) == 0) w.coef = rand16();
        send(w, 1'b0, r);
      end
    end

    cnt = 0;
    while (cnt < 900) begin
      if ($urandom_range(0, 9) < 8) begin
        ch = $urandom_range(0, NCH - 1);
        n = $urandom_range(1, 4);
        for (int s = 0; s < n; s++) begin
          w = rand_scan(ch, $urandom_range(0, NST - 1), $urandom_range(0, 7) == 0,
                        s == n - 1);
          send(w, 1'b0, r);
          cnt++;
        end
      end else begin
        w = rand_scan($urandom_range(0, NCH - 1), $urandom_range(0, NST - 1),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        w.func = 2'($urandom_range(0, 3));
        w.coef = (w.func == FUNC_DECAY) ?
                 16'($signed($urandom_range(0, 2047)) - 1536) : rand16();
        send(w, 1'b0, r);
        if (w.func != FUNC_NONE) cnt++;
      end
    end
    s_tvalid <= 1'b0;

    while (pending_y.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && pending_y.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    if (!done) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
